/* hdl/gwim_pkg.sv */
// ============================================================================
// gwim_pkg : shared types, constants and the exponential table builder
// Holds the field widths, command codes and the falloff table contents used
// by the inverse warp map core.
// ============================================================================
`default_nettype none

package gwim_pkg;

  // Field widths
  localparam int COORD_W = 16;   // target position, unsigned Q12.4
  localparam int PIX_W   = 12;   // integer pixel coordinate
  localparam int SHIFT_W = 12;   // displacement, signed Q.4
  localparam int FALL_W  = 16;   // falloff, unsigned Q0.16
  localparam int OUT_W   = 18;   // source coordinate, signed Q.4
  localparam int WGT_W   = 16;   // weight from the table
  localparam int CFG_W   = 4;

  localparam int OUT_MIN = -16384;
  localparam int OUT_MAX = 81919;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  // Largest table the core can be built with
  localparam int ROM_MAX_DEPTH = 4096;
  localparam int ROM_MAX_AW    = 12;

  typedef logic [ROM_MAX_DEPTH-1:0][WGT_W-1:0] exp_rom_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } gwim_state_t;

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  // (a*b) >> 62 for operands up to one in Q62, from 31-bit halves
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ah, al, bh, bl, hi, mid, lo;
    ah  = a >> 31;
    al  = a & 64'h7FFF_FFFF;
    bh  = b >> 31;
    bl  = b & 64'h7FFF_FFFF;
    hi  = ah * bh;
    mid = ah * bl + al * bh;
    lo  = al * bl;
    return hi + ((mid + (lo >> 31)) >> 31);
  endfunction

  // Weight table: round(65535 * exp(-k/64)), built in Q62 integer arithmetic.
  // Evaluated once at elaboration.
  function automatic exp_rom_t exp_rom_build();
    logic [63:0] term, ratio, p, v;
    exp_rom_t    rom;
    term  = ONE_Q62;
    ratio = ONE_Q62;
    p     = ONE_Q62;
    // exp(-1/64) by a Taylor series of fourteen terms
    term = term / 64;   ratio = ratio - term;
    term = term / 128;  ratio = ratio + term;
    term = term / 192;  ratio = ratio - term;
    term = term / 256;  ratio = ratio + term;
    term = term / 320;  ratio = ratio - term;
    term = term / 384;  ratio = ratio + term;
    term = term / 448;  ratio = ratio - term;
    term = term / 512;  ratio = ratio + term;
    term = term / 576;  ratio = ratio - term;
    term = term / 640;  ratio = ratio + term;
    term = term / 704;  ratio = ratio - term;
    term = term / 768;  ratio = ratio + term;
    term = term / 832;  ratio = ratio - term;
    term = term / 896;  ratio = ratio + term;
    for (int k = 0; k < ROM_MAX_DEPTH; k++) begin
      v      = 64'd65535 * (p >> 16);
      rom[k] = WGT_W'((v + (64'd1 << 45)) >> 46);
      p      = mul_q62(p, ratio);
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

/* hdl/gaussian_warp_inverse_map_core.sv */
// ============================================================================
// gaussian_warp_inverse_map_core : Gaussian radial-basis inverse warp map
// Keeps a table of control points in two small synchronous memories and, for
// each pixel, pulls the sample position back by the weighted displacement of
// every active point. Result is the source coordinate in signed Q.4.
// ============================================================================
//
//  Channel   Handshake            Carries
//  --------  -------------------  ----------------------------------------------
//  config    cfg_we               cfg_wdata -> active_points (no wait)
//  in        in_valid / in_ready  cmd, point_index, target/shift/falloff, pixel
//  out       out_valid/out_ready  source_x, source_y (one per pixel transfer)
//
//  A load transfer writes the point memories at its edge.
//  A pixel with n >= 1 active points issues one memory read a cycle through a
//  six-stage datapath (square, sum, scale, table read, weight, accumulate);
//  the result is loaded into the output register from the done state, and
//  the next input transfer is taken only once the block is back in idle, so
//  a pixel is finished before the next is taken; the single read port
//  serialises its points. rst (synchronous) clears control state only; the
//  point memories are undefined until written. A stalled output holds its
//  register; the block then finishes the next pixel and waits in its done state.
// ============================================================================
`default_nettype none

module gaussian_warp_inverse_map_core #(
  parameter int MAX_POINTS      = 8,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic        [gwim_pkg::CFG_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 cmd,
  input  wire logic        [2:0]                    point_index,
  input  wire logic        [gwim_pkg::COORD_W-1:0]  target_x,
  input  wire logic        [gwim_pkg::COORD_W-1:0]  target_y,
  input  wire logic signed [gwim_pkg::SHIFT_W-1:0]  shift_x,
  input  wire logic signed [gwim_pkg::SHIFT_W-1:0]  shift_y,
  input  wire logic        [gwim_pkg::FALL_W-1:0]   falloff,
  input  wire logic        [gwim_pkg::PIX_W-1:0]    pixel_x,
  input  wire logic        [gwim_pkg::PIX_W-1:0]    pixel_y,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [gwim_pkg::OUT_W-1:0]    source_x,
  output logic signed      [gwim_pkg::OUT_W-1:0]    source_y
);

  import gwim_pkg::*;

  localparam int PA_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int KW     = $clog2(EXP_TABLE_DEPTH);
  localparam int ACC_W  = 20 + $clog2(MAX_POINTS);
  localparam int POS_W  = 2 * COORD_W;
  localparam int SF_W   = 2 * SHIFT_W + FALL_W;
  localparam int SQ_W   = 2 * COORD_W;            // one squared axis error
  localparam int D2_W   = SQ_W + 1;
  localparam int PR_W   = D2_W + FALL_W;
  localparam int KF_W   = PR_W - 18;
  localparam int PX_W   = WGT_W + 1 + SHIFT_W;
  localparam int DX_W   = PX_W - 16;
  localparam int NSTAGE = 6;

  localparam exp_rom_t EXP_ROM = exp_rom_build();

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  gwim_state_t state, state_next;

  logic [CFG_W-1:0]      active_points;
  logic [CNT_W-1:0]      n_pts;
  logic [CNT_W-1:0]      issue_cnt;
  logic [NSTAGE-1:0]     pipe_v;
  logic [COORD_W-1:0]    ax, ay;
  logic signed [ACC_W-1:0] acc_x, acc_y;

  logic in_xfer, load_we, map_start, issue, out_load;
  logic [CNT_W-1:0] n_sat;

  assign in_xfer   = in_valid && in_ready;
  assign load_we   = in_xfer && (cmd == CMD_LOAD) && (32'(point_index) < MAX_POINTS);
  assign map_start = in_xfer && (cmd == CMD_MAP);

  // Saturate the point count to the table size
  always_comb begin
    if (32'(active_points) > MAX_POINTS) begin
      n_sat = CNT_W'(MAX_POINTS);
    end else begin
      n_sat = CNT_W'(active_points);
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (map_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = (issue_cnt < n_pts);
        // last read issued and every stage drained
        if (!issue && (pipe_v == '0)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_points <= '0;
      n_pts         <= '0;
      issue_cnt     <= '0;
      pipe_v        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state  <= state_next;
      pipe_v <= {pipe_v[NSTAGE-2:0], issue};
      if (cfg_we) begin
        active_points <= cfg_wdata;
      end
      if (map_start) begin
        n_pts     <= n_sat;
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Point memories: one write port (load transfer), one read port (issue)
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] pos_mem [MAX_POINTS];
  logic [SF_W-1:0]  sf_mem  [MAX_POINTS];
  logic [POS_W-1:0] pos_q;
  logic [SF_W-1:0]  sf_q;

  always_ff @(posedge clk) begin
    if (load_we) begin
      pos_mem[PA_W'(point_index)] <= {target_y, target_x};
      sf_mem[PA_W'(point_index)]  <= {falloff, shift_y, shift_x};
    end
    if (issue) begin
      pos_q <= pos_mem[issue_cnt[PA_W-1:0]];
      sf_q  <= sf_mem[issue_cnt[PA_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [COORD_W:0]     ex, ey;
  logic signed [2*COORD_W+1:0] sq_x, sq_y;

  assign ex   = $signed({1'b0, ax}) - $signed({1'b0, pos_q[COORD_W-1:0]});
  assign ey   = $signed({1'b0, ay}) - $signed({1'b0, pos_q[POS_W-1:COORD_W]});
  assign sq_x = ex * ex;
  assign sq_y = ey * ey;

  // stage 1: squared errors
  logic [SQ_W-1:0]           ex2, ey2;
  logic signed [SHIFT_W-1:0] sx1, sy1;
  logic [FALL_W-1:0]         fall1;
  // stage 2: squared distance
  logic [D2_W-1:0]           d2;
  logic signed [SHIFT_W-1:0] sx2, sy2;
  logic [FALL_W-1:0]         fall2;
  // stage 3: scaled distance
  logic [PR_W-1:0]           prod;
  logic signed [SHIFT_W-1:0] sx3, sy3;
  // stage 4: table read
  logic [WGT_W-1:0]          w_q;
  logic signed [SHIFT_W-1:0] sx4, sy4;
  // stage 5: weighted shifts
  logic signed [PX_W-1:0]    px, py;

  logic [KF_W-1:0] k_full;
  logic [KW-1:0]   rom_addr;
  logic signed [DX_W-1:0] dx, dy;

  assign k_full = prod[PR_W-1:18];

  // Clamp the index to the last table entry
  always_comb begin
    if (k_full > KF_W'(EXP_TABLE_DEPTH - 1)) begin
      rom_addr = KW'(EXP_TABLE_DEPTH - 1);
    end else begin
      rom_addr = k_full[KW-1:0];
    end
  end

  // arithmetic shift floors toward minus infinity
  assign dx = px[PX_W-1:16];
  assign dy = py[PX_W-1:16];

  always_ff @(posedge clk) begin
    ex2   <= SQ_W'(unsigned'(sq_x));
    ey2   <= SQ_W'(unsigned'(sq_y));
    sx1   <= sf_q[SHIFT_W-1:0];
    sy1   <= sf_q[2*SHIFT_W-1:SHIFT_W];
    fall1 <= sf_q[SF_W-1:2*SHIFT_W];

    d2    <= {1'b0, ex2} + {1'b0, ey2};
    sx2   <= sx1;
    sy2   <= sy1;
    fall2 <= fall1;

    prod  <= d2 * fall2;
    sx3   <= sx2;
    sy3   <= sy2;

    w_q   <= EXP_ROM[ROM_MAX_AW'(rom_addr)];
    sx4   <= sx3;
    sy4   <= sy3;

    px    <= $signed({1'b0, w_q}) * sx4;
    py    <= $signed({1'b0, w_q}) * sy4;
  end

  // Accumulators start at the pixel position and drop each weighted shift
  always_ff @(posedge clk) begin
    if (map_start) begin
      ax    <= {pixel_x, 4'b0000};
      ay    <= {pixel_y, 4'b0000};
      acc_x <= ACC_W'($signed({1'b0, pixel_x, 4'b0000}));
      acc_y <= ACC_W'($signed({1'b0, pixel_y, 4'b0000}));
    end else if (pipe_v[NSTAGE-1]) begin
      acc_x <= acc_x - ACC_W'(dx);
      acc_y <= acc_y - ACC_W'(dy);
    end
  end

  // --------------------------------------------------------------------------
  // Output register with saturation
  // --------------------------------------------------------------------------
  logic signed [OUT_W-1:0] sat_x, sat_y;

  always_comb begin
    priority if (acc_x < ACC_W'(OUT_MIN)) begin
      sat_x = OUT_W'(OUT_MIN);
    end else if (acc_x > ACC_W'(OUT_MAX)) begin
      sat_x = OUT_W'(OUT_MAX);
    end else begin
      sat_x = acc_x[OUT_W-1:0];
    end
    priority if (acc_y < ACC_W'(OUT_MIN)) begin
      sat_y = OUT_W'(OUT_MIN);
    end else if (acc_y > ACC_W'(OUT_MAX)) begin
      sat_y = OUT_W'(OUT_MAX);
    end else begin
      sat_y = acc_y[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      source_x <= sat_x;
      source_y <= sat_y;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (pipe_v == '0))
    else $error("input taken while datapath busy");

  a_issue_bound : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (issue_cnt <= n_pts))
    else $error("issue count beyond active points");

  a_load_drained : assert property (@(posedge clk) disable iff (rst)
    out_load |-> ((pipe_v == '0) && (issue_cnt == n_pts)))
    else $error("result loaded before all points accumulated");

  a_accum_in_run : assert property (@(posedge clk) disable iff (rst)
    pipe_v[NSTAGE-1] |-> (state == ST_RUN))
    else $error("accumulate outside a pixel pass");

  a_out_from_done : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid) && !$past(rst)) |-> ($past(state) == ST_DONE))
    else $error("result shown without a finished pixel");

endmodule

`default_nettype wire

/* tb/sv/gwim_source_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwim_source_checker : result checker for the inverse warp map core
// Watches the configuration port and both channels. It keeps its own control
// point table and weight table, predicts the source coordinate of every
// pixel transfer and compares each output transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------

module gwim_source_checker
  import gwim_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic        [CFG_W-1:0]   cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      cmd,
  input  logic        [2:0]         point_index,
  input  logic        [COORD_W-1:0] target_x,
  input  logic        [COORD_W-1:0] target_y,
  input  logic signed [SHIFT_W-1:0] shift_x,
  input  logic signed [SHIFT_W-1:0] shift_y,
  input  logic        [FALL_W-1:0]  falloff,
  input  logic        [PIX_W-1:0]   pixel_x,
  input  logic        [PIX_W-1:0]   pixel_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [OUT_W-1:0]   source_x,
  input  logic signed [OUT_W-1:0]   source_y,
  output int                        fail_count,
  output int                        results_seen,
  output int                        pending_results
);

  localparam int POINT_SLOTS  = 8;
  localparam int LUT_DEPTH    = 1024;
  localparam longint unsigned Q62_UNIT = 64'd1 << 62;

  typedef struct packed {
    logic        [COORD_W-1:0] tx;
    logic        [COORD_W-1:0] ty;
    logic signed [SHIFT_W-1:0] sx;
    logic signed [SHIFT_W-1:0] sy;
    logic        [FALL_W-1:0]  fall;
  } ctrl_point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } source_pos_t;

  logic [WGT_W-1:0] gauss_lut [LUT_DEPTH];
  ctrl_point_t      point_slots [POINT_SLOTS];
  logic [CFG_W-1:0] active_points_q;
  source_pos_t      source_q [$];

  // (a*b) >> 62, split into 31-bit halves so nothing overflows
  function automatic longint unsigned q62_product(input longint unsigned a,
                                                  input longint unsigned b);
    longint unsigned ah, al, bh, bl;
    ah = a >> 31;
    al = a & 64'h7FFF_FFFF;
    bh = b >> 31;
    bl = b & 64'h7FFF_FFFF;
    return ah * bh + ((ah * bl + al * bh + ((al * bl) >> 31)) >> 31);
  endfunction

  // round(65535 * exp(-k/64)) by repeated multiplication with exp(-1/64)
  function automatic void fill_gauss_lut();
    longint unsigned term, step_ratio, acc;
    term       = Q62_UNIT;
    step_ratio = Q62_UNIT;
    acc        = Q62_UNIT;
    for (int n = 1; n <= 14; n++) begin
      term = term / longint'(64 * n);
      if (n % 2 == 1) step_ratio = step_ratio - term;
      else step_ratio = step_ratio + term;
    end
    for (int k = 0; k < LUT_DEPTH; k++) begin
      gauss_lut[k] = WGT_W'((64'd65535 * (acc >> 16) + (64'd1 << 45)) >> 46);
      acc = q62_product(acc, step_ratio);
    end
  endfunction

  function automatic source_pos_t warp_source(input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py);
    longint      ax, ay, ox, oy, ex, ey, d2, k, w;
    int          used;
    ctrl_point_t pt;
    source_pos_t pos;
    ax   = longint'(px) * 16;
    ay   = longint'(py) * 16;
    ox   = ax;
    oy   = ay;
    used = (active_points_q > POINT_SLOTS) ? POINT_SLOTS : int'(active_points_q);
    for (int i = 0; i < used; i++) begin
      pt = point_slots[i];
      ex = ax - longint'(pt.tx);
      ey = ay - longint'(pt.ty);
      d2 = ex * ex + ey * ey;
      k  = (d2 * longint'(pt.fall)) >>> 18;
      if (k > LUT_DEPTH - 1) k = LUT_DEPTH - 1;
      w  = longint'(gauss_lut[k]);
      // arithmetic shift floors towards minus infinity
      ox = ox - ((w * longint'(pt.sx)) >>> 16);
      oy = oy - ((w * longint'(pt.sy)) >>> 16);
    end
    if (ox < OUT_MIN) ox = OUT_MIN;
    if (ox > OUT_MAX) ox = OUT_MAX;
    if (oy < OUT_MIN) oy = OUT_MIN;
    if (oy > OUT_MAX) oy = OUT_MAX;
    pos.x = OUT_W'(ox);
    pos.y = OUT_W'(oy);
    return pos;
  endfunction

  initial begin
    fail_count      = 0;
    results_seen    = 0;
    pending_results = 0;
    fill_gauss_lut();
  end

  always @(posedge clk) begin
    source_pos_t want;
    ctrl_point_t pt;
    if (rst) begin
      active_points_q = '0;
      for (int i = 0; i < POINT_SLOTS; i++) point_slots[i] = '0;
      source_q.delete();
    end else begin
      if (cfg_we) active_points_q = cfg_wdata;

      // retire results before taking new work
      if (out_valid && out_ready) begin
        results_seen++;
        if (source_q.size() == 0) begin
          $display("%0t: result (%0d, %0d) with nothing outstanding",
                   $time, source_x, source_y);
          fail_count++;
        end else begin
          want = source_q.pop_front();
          if (source_x !== want.x) begin
            $display("%0t: source_x expected %0d, got %0d", $time, want.x, source_x);
            fail_count++;
          end
          if (source_y !== want.y) begin
            $display("%0t: source_y expected %0d, got %0d", $time, want.y, source_y);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (cmd == CMD_LOAD) begin
          if (point_index < POINT_SLOTS) begin
            pt.tx   = target_x;
            pt.ty   = target_y;
            pt.sx   = shift_x;
            pt.sy   = shift_y;
            pt.fall = falloff;
            point_slots[point_index] = pt;
          end
        end else begin
          source_q.insert(source_q.size(), warp_source(pixel_x, pixel_y));
        end
      end
    end
    pending_results <= source_q.size();
  end

endmodule

/* tb/sv/gaussian_warp_inverse_map_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_warp_inverse_map_core_test : top of the inverse warp map testbench
// Drives control point loads and pixel maps into the core under random input
// gaps and output stalls, steps the active point count through a series of
// settings and leaves all prediction and comparison to gwim_source_checker.
// ----------------------------------------------------------------------------

module gaussian_warp_inverse_map_core_test;
  import gwim_pkg::*;

  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 140;
  // settle pause after a drain, with margin over a pixel with every point active
  localparam int SETTLE_CYCLES   = 24;
  // longest correct quiet spell is a gap, a full pixel and a stall, or a
  // settle pause before a register write; this is many times that
  localparam int QUIET_LIMIT     = 2000;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_we      = 1'b0;
  logic        [CFG_W-1:0]   cfg_wdata   = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic                      cmd         = CMD_MAP;
  logic        [2:0]         point_index = '0;
  logic        [COORD_W-1:0] target_x    = '0;
  logic        [COORD_W-1:0] target_y    = '0;
  logic signed [SHIFT_W-1:0] shift_x     = '0;
  logic signed [SHIFT_W-1:0] shift_y     = '0;
  logic        [FALL_W-1:0]  falloff     = '0;
  logic        [PIX_W-1:0]   pixel_x     = '0;
  logic        [PIX_W-1:0]   pixel_y     = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic signed [OUT_W-1:0]   source_x;
  logic signed [OUT_W-1:0]   source_y;

  int fail_count;
  int results_seen;
  int pending_results;
  int quiet_cycles = 0;

  // Stimulus bookkeeping: where each slot's target sits in whole pixels, so
  // that pixel maps can be steered close enough for the weights to matter.
  int tgt_col [8];
  int tgt_row [8];
  int loads_sent    = 0;
  int maps_sent     = 0;
  int settings_used = 0;
  bit in_calm       = 1'b0;

  always #5 clk = ~clk;

  gaussian_warp_inverse_map_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .point_index (point_index),
    .target_x    (target_x),
    .target_y    (target_y),
    .shift_x     (shift_x),
    .shift_y     (shift_y),
    .falloff     (falloff),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .source_x    (source_x),
    .source_y    (source_y)
  );

  gwim_source_checker map_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .point_index     (point_index),
    .target_x        (target_x),
    .target_y        (target_y),
    .shift_x         (shift_x),
    .shift_y         (shift_y),
    .falloff         (falloff),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .source_x        (source_x),
    .source_y        (source_y),
    .fail_count      (fail_count),
    .results_seen    (results_seen),
    .pending_results (pending_results)
  );

  // Present one request and hold it until the transfer edge. Called on a
  // rising edge; returns on the edge at which the transfer happened. When
  // the drawn gap is zero, valid simply stays high with the new payload, so
  // it never gets two assignments in one step.
  task automatic push_request(input logic               op,
                              input logic [2:0]         slot,
                              input logic [COORD_W-1:0] tx,
                              input logic [COORD_W-1:0] ty,
                              input logic [SHIFT_W-1:0] sx,
                              input logic [SHIFT_W-1:0] sy,
                              input logic [FALL_W-1:0]  fall,
                              input logic [PIX_W-1:0]   px,
                              input logic [PIX_W-1:0]   py);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= op;
    point_index <= slot;
    target_x    <= tx;
    target_y    <= ty;
    shift_x     <= sx;
    shift_y     <= sy;
    falloff     <= fall;
    pixel_x     <= px;
    pixel_y     <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Load a control point; fill the pixel fields with noise, the core must
  // ignore them.
  task automatic load_point(input logic [2:0]         slot,
                            input logic [COORD_W-1:0] tx,
                            input logic [COORD_W-1:0] ty,
                            input logic [SHIFT_W-1:0] sx,
                            input logic [SHIFT_W-1:0] sy,
                            input logic [FALL_W-1:0]  fall);
    tgt_col[slot] = int'(tx >> 4);
    tgt_row[slot] = int'(ty >> 4);
    loads_sent++;
    push_request(CMD_LOAD, slot, tx, ty, sx, sy, fall,
                 PIX_W'($urandom), PIX_W'($urandom));
  endtask

  // Map one pixel; the point fields carry noise.
  task automatic map_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    maps_sent++;
    push_request(CMD_MAP, 3'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 SHIFT_W'($urandom), SHIFT_W'($urandom), FALL_W'($urandom), px, py);
  endtask

  // Drop valid and wait for every prediction to be met, then let the core
  // settle so that a register write lands on an idle block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_points(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(value);
    settings_used++;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Count edges with no transfer of any kind; reset and register writes
  // count as activity.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_results);
    $display("gaussian_warp_inverse_map_core_test: FAIL");
    $finish;
  end

  // Output side: draw a stall per result, with calm stretches that take
  // every result at once.
  initial begin
    int stall;
    int taken;
    bit out_calm;
    taken    = 0;
    out_calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 32 == 0) out_calm = ($urandom_range(0, 3) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    int setting;
    int roll;
    int slot;
    int col;
    int row;
    int fall;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: no active points passes pixels straight through
    write_active_points(0);
    map_pixel(12'd0, 12'd0);
    map_pixel(12'd4095, 12'd4095);

    // Fill every slot before any setting can read one; cover the extreme
    // targets, both shift limits, zero falloff and a falloff above range.
    load_point(3'd0, 16'd0, 16'd0, -12'sd2048, 12'sd2047, 16'hFFFF);
    load_point(3'd1, 16'hFFFF, 16'hFFFF, 12'sd2047, -12'sd2048, 16'd0);
    load_point(3'd2, 16'd1600, 16'd3200, 12'sd800, -12'sd300, 16'd32768);
    load_point(3'd3, 16'd32008, 16'd16000, -12'sd1, 12'sd1, 16'd1);
    load_point(3'd4, 16'd65520, 16'd0, 12'sd0, 12'sd0, 16'd600);
    load_point(3'd5, 16'd0, 16'd65520, -12'sd2048, -12'sd2048, 16'd20);
    load_point(3'd6, 16'd800, 16'd800, 12'sd2047, 12'sd2047, 16'd3000);
    load_point(3'd7, 16'd48015, 16'd48015, 12'sd1000, -12'sd1000, 16'd100);

    // Directed: every point active, pixels on and around the targets
    drain();
    write_active_points(8);
    map_pixel(12'd0, 12'd0);
    map_pixel(12'd4095, 12'd4095);
    map_pixel(12'd100, 12'd200);
    map_pixel(12'd50, 12'd50);
    map_pixel(12'd2000, 12'd1000);
    map_pixel(12'd3000, 12'd3000);
    map_pixel(12'd4095, 12'd0);
    map_pixel(12'd0, 12'd4095);

    // Directed: a count above the table size must saturate
    drain();
    write_active_points(15);
    map_pixel(12'd50, 12'd50);
    map_pixel(12'd100, 12'd200);

    // Random phases: the first few settings are fixed extremes, the rest
    // are drawn from the whole register range.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       setting = 1;
        1:       setting = 0;
        2:       setting = 15;
        3:       setting = 8;
        default: setting = $urandom_range(0, 15);
      endcase
      drain();
      write_active_points(setting);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 32 == 0) in_calm = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          // Mostly narrow falloffs so that nearby pixels get real weights;
          // the rest over the nominal range and over all sixteen bits.
          case ($urandom_range(0, 3))
            0, 1:    fall = $urandom_range(0, 2000);
            2:       fall = $urandom_range(0, 32768);
            default: fall = $urandom_range(0, 65535);
          endcase
          load_point(3'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     SHIFT_W'($urandom), SHIFT_W'($urandom), FALL_W'(fall));
        end else if (roll < 92) begin
          // Land within a couple of dozen pixels of some point's target
          slot = $urandom_range(0, 7);
          col  = tgt_col[slot] + int'($urandom_range(0, 48)) - 24;
          row  = tgt_row[slot] + int'($urandom_range(0, 48)) - 24;
          if (col < 0) col = 0;
          if (col > 4095) col = 4095;
          if (row < 0) row = 0;
          if (row > 4095) row = 4095;
          map_pixel(PIX_W'(col), PIX_W'(row));
        end else begin
          map_pixel(PIX_W'($urandom), PIX_W'($urandom));
        end
      end
    end

    drain();
    $display("Sent %0d point loads and %0d pixel maps across %0d active point settings,",
             loads_sent, maps_sent, settings_used);
    $display("checked %0d source coordinates under random gaps and output stalls.",
             results_seen);
    if (fail_count == 0)
      $display("gaussian_warp_inverse_map_core_test: PASS");
    else
      $display("gaussian_warp_inverse_map_core_test: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/gwim_pkg.sv
hdl/gaussian_warp_inverse_map_core.sv
tb/sv/gwim_source_checker.sv
tb/sv/gaussian_warp_inverse_map_core_test.sv
